>>> design/lrp_pkg.sv
// ----------------------------------------------------------------------------
// lrp_pkg - shared types and constants of the LR parser driver
// Field widths, table geometry, opcode and status codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package lrp_pkg;

	localparam int STATE_W      = 8;
	localparam int SYM_W        = 6;
	localparam int PROD_W       = 7;
	localparam int POS_W        = 3;
	localparam int LEN_W        = 4;
	localparam int MAX_RHS      = 8;
	localparam int STACK_DEPTH  = 64;
	localparam int SP_W         = 6;
	localparam int NUM_SYMBOLS  = 64;
	localparam int REDUCE_LIMIT = STACK_DEPTH * NUM_SYMBOLS;
	localparam int RED_W        = 13;
	localparam int ACT_AW       = STATE_W + SYM_W;
	localparam int RHS_AW       = PROD_W + POS_W;
	localparam int CNT_W        = 16;

	typedef enum logic [2:0] {
		OP_WR_ACTION = 3'd0,
		OP_WR_HEADER = 3'd1,
		OP_WR_RHS    = 3'd2,
		OP_START     = 3'd3,
		OP_TOKEN     = 3'd4,
		OP_END       = 3'd5
	} lrp_op_t;

	typedef enum logic [1:0] {
		KIND_ERROR  = 2'd0,
		KIND_SHIFT  = 2'd1,
		KIND_REDUCE = 2'd2,
		KIND_ACCEPT = 2'd3
	} lrp_kind_t;

	typedef enum logic [2:0] {
		ST_SHIFTED    = 3'd0,
		ST_ACCEPTED   = 3'd1,
		ST_UNEXPECTED = 3'd2,
		ST_MISMATCH   = 3'd3,
		ST_BADTABLE   = 3'd4,
		ST_INCOMPLETE = 3'd5,
		ST_OVERFLOW   = 3'd6
	} lrp_status_t;

	// action table read address source
	typedef enum logic [1:0] {
		ARD_NONE  = 2'd0,
		ARD_LOOK  = 2'd1,
		ARD_GOTO  = 2'd2,
		ARD_AFTER = 2'd3
	} lrp_ard_t;

	typedef struct packed {
		logic        wr_action;
		logic        wr_header;
		logic        wr_rhs;
		logic        init;
		logic        load_item;
		lrp_ard_t    act_rd;
		logic        prod_rd;
		logic        load_j;
		logic        rhs_rd;
		logic        j_dec;
		logic        pop;
		logic        st_rd;
		logic        tos_load;
		logic        push_shift;
		logic        push_goto;
		logic        emit;
		lrp_status_t emit_status;
	} lrp_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       num_big;
		logic       sp_zero;
		logic       sp_full;
		logic       red_limit;
		logic       j_zero;
		logic       rhs_zero;
		logic       sym_match;
		logic       goto_zero;
		logic       done;
		logic       is_end;
		logic       out_busy;
	} lrp_stat_t;

endpackage
`default_nettype wire

>>> design/lrp_in_if.sv
// ----------------------------------------------------------------------------
// lrp_in_if - input channel of the LR parser driver
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
`default_nettype none
interface lrp_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [7:0] table_state;
	logic [5:0] table_symbol;
	logic [1:0] action_kind;
	logic [7:0] action_number;
	logic [6:0] production_index;
	logic [2:0] rhs_position;
	logic [5:0] rhs_value;
	logic [3:0] rhs_length;
	logic [5:0] lhs_symbol;
	logic [5:0] token_symbol;

	modport source (output valid, opcode, table_state, table_symbol, action_kind,
		action_number, production_index, rhs_position, rhs_value, rhs_length,
		lhs_symbol, token_symbol, input ready);
	modport sink (input valid, opcode, table_state, table_symbol, action_kind,
		action_number, production_index, rhs_position, rhs_value, rhs_length,
		lhs_symbol, token_symbol, output ready);
endinterface
`default_nettype wire

>>> design/lrp_out_if.sv
// ----------------------------------------------------------------------------
// lrp_out_if - result channel of the LR parser driver
// Valid/ready channel carrying one parse result.
// ----------------------------------------------------------------------------
`default_nettype none
interface lrp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] element_position;
	logic [5:0]  offending_symbol;
	logic [6:0]  failed_production;

	modport source (output valid, status, element_position, offending_symbol,
		failed_production, input ready);
	modport sink (input valid, status, element_position, offending_symbol,
		failed_production, output ready);
endinterface
`default_nettype wire

>>> design/lrp_datapath.sv
// ----------------------------------------------------------------------------
// lrp_datapath - tables, stacks and result register
// Holds the action, production and stack memories, the stack pointer and
// counters, and the output register; acts on controller commands.
// ----------------------------------------------------------------------------
`default_nettype none
module lrp_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lrp_pkg::lrp_cmd_t cmd,
	output lrp_pkg::lrp_stat_t stat,
	lrp_in_if.sink             in_ch,
	lrp_out_if.source          out_ch
);

	logic [9:0]                       act_mem [0:(1 << lrp_pkg::ACT_AW) - 1];
	logic [lrp_pkg::LEN_W-1:0]        len_mem [0:(1 << lrp_pkg::PROD_W) - 1];
	logic [lrp_pkg::SYM_W-1:0]        lhs_mem [0:(1 << lrp_pkg::PROD_W) - 1];
	logic [lrp_pkg::SYM_W-1:0]        rhs_mem [0:(1 << lrp_pkg::RHS_AW) - 1];
	logic [lrp_pkg::STATE_W-1:0]      st_mem  [0:lrp_pkg::STACK_DEPTH-1];
	logic [lrp_pkg::SYM_W-1:0]        sym_mem [0:lrp_pkg::STACK_DEPTH-1];

	logic [9:0]                  act_rdata_q;
	logic [lrp_pkg::LEN_W-1:0]   len_rdata_q;
	logic [lrp_pkg::SYM_W-1:0]   lhs_rdata_q;
	logic [lrp_pkg::SYM_W-1:0]   rhs_rdata_q;
	logic [lrp_pkg::SYM_W-1:0]   sym_rdata_q;
	logic [lrp_pkg::STATE_W-1:0] st_rdata_q;

	logic [lrp_pkg::SP_W-1:0]    sp_q;
	logic [lrp_pkg::STATE_W-1:0] tos_q;
	logic [lrp_pkg::SYM_W-1:0]   look_q;
	logic                        is_end_q;
	logic                        done_q;
	logic [lrp_pkg::CNT_W-1:0]   tc_q;
	logic [lrp_pkg::RED_W-1:0]   red_q;
	logic [lrp_pkg::PROD_W-1:0]  num_q;
	logic [lrp_pkg::LEN_W-1:0]   j_q;
	logic [lrp_pkg::SYM_W-1:0]   lhs_q;

	logic                        out_valid_q;
	logic [2:0]                  out_status_q;
	logic [lrp_pkg::CNT_W-1:0]   out_pos_q;
	logic [lrp_pkg::SYM_W-1:0]   out_sym_q;
	logic [lrp_pkg::PROD_W-1:0]  out_prod_q;

	logic [lrp_pkg::SYM_W-1:0]   look_next;
	logic [lrp_pkg::STATE_W-1:0] tos_new;
	logic [lrp_pkg::ACT_AW-1:0]  act_addr;
	logic [lrp_pkg::LEN_W-1:0]   j_m1;
	logic [lrp_pkg::LEN_W-1:0]   len_sat;
	logic [lrp_pkg::SP_W-1:0]    sp_inc;
	logic                        push;
	logic [lrp_pkg::CNT_W-1:0]   pos;

	assign look_next = (in_ch.opcode == lrp_pkg::OP_END) ? '0 : in_ch.token_symbol;
	assign tos_new   = (sp_q == '0) ? lrp_pkg::STATE_W'(1) : st_rdata_q;
	assign j_m1      = j_q - lrp_pkg::LEN_W'(1);
	assign len_sat   = (in_ch.rhs_length > lrp_pkg::LEN_W'(lrp_pkg::MAX_RHS)) ?
		lrp_pkg::LEN_W'(lrp_pkg::MAX_RHS) : in_ch.rhs_length;
	assign sp_inc    = sp_q + lrp_pkg::SP_W'(1);
	assign push      = cmd.push_shift | cmd.push_goto;
	assign pos       = (tc_q == '1) ? tc_q : tc_q + lrp_pkg::CNT_W'(1);

	always_comb begin
		case (cmd.act_rd)
			lrp_pkg::ARD_LOOK:  act_addr = {tos_q, (cmd.load_item ? look_next : look_q)};
			lrp_pkg::ARD_GOTO:  act_addr = {tos_new, lhs_q};
			lrp_pkg::ARD_AFTER: act_addr = {act_rdata_q[7:0], look_q};
			default:            act_addr = '0;
		endcase
	end

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (cmd.wr_action) begin
			act_mem[{in_ch.table_state, in_ch.table_symbol}] <=
				{in_ch.action_kind, in_ch.action_number};
		end
		if (cmd.act_rd != lrp_pkg::ARD_NONE) begin
			act_rdata_q <= act_mem[act_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_header) begin
			len_mem[in_ch.production_index] <= len_sat;
			lhs_mem[in_ch.production_index] <= in_ch.lhs_symbol;
		end
		if (cmd.prod_rd) begin
			len_rdata_q <= len_mem[act_rdata_q[6:0]];
			lhs_rdata_q <= lhs_mem[act_rdata_q[6:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_rhs) begin
			rhs_mem[{in_ch.production_index, in_ch.rhs_position}] <= in_ch.rhs_value;
		end
		if (cmd.rhs_rd) begin
			rhs_rdata_q <= rhs_mem[{num_q, j_m1[lrp_pkg::POS_W-1:0]}];
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			st_mem[sp_inc]  <= act_rdata_q[7:0];
			sym_mem[sp_inc] <= cmd.push_shift ? look_q : lhs_q;
		end
		if (cmd.rhs_rd) begin
			sym_rdata_q <= sym_mem[sp_q];
		end
		if (cmd.st_rd) begin
			st_rdata_q <= st_mem[sp_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			look_q   <= look_next;
			is_end_q <= (in_ch.opcode == lrp_pkg::OP_END);
		end
		if (cmd.prod_rd) begin
			num_q <= act_rdata_q[6:0];
		end
		if (cmd.load_j) begin
			j_q   <= len_rdata_q;
			lhs_q <= lhs_rdata_q;
		end else if (cmd.j_dec) begin
			j_q <= j_m1;
		end
		if (cmd.emit) begin
			out_status_q <= cmd.emit_status;
			out_pos_q    <= pos;
			out_sym_q    <= look_q;
			out_prod_q   <= (cmd.emit_status == lrp_pkg::ST_MISMATCH) ? num_q : '0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			tos_q       <= lrp_pkg::STATE_W'(1);
			tc_q        <= '0;
			done_q      <= 1'b0;
			red_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init) begin
				sp_q   <= '0;
				tos_q  <= lrp_pkg::STATE_W'(1);
				tc_q   <= '0;
				done_q <= 1'b0;
			end else begin
				if (push) begin
					sp_q  <= sp_inc;
					tos_q <= act_rdata_q[7:0];
				end else if (cmd.pop) begin
					sp_q <= sp_q - lrp_pkg::SP_W'(1);
				end else if (cmd.tos_load) begin
					tos_q <= tos_new;
				end
				if (cmd.push_shift && !is_end_q && tc_q != '1) begin
					tc_q <= tc_q + lrp_pkg::CNT_W'(1);
				end
				if (cmd.emit && cmd.emit_status != lrp_pkg::ST_SHIFTED) begin
					done_q <= 1'b1;
				end
			end
			if (cmd.load_item) begin
				red_q <= '0;
			end else if (cmd.prod_rd) begin
				red_q <= red_q + lrp_pkg::RED_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.kind      = act_rdata_q[9:8];
	assign stat.num_big   = act_rdata_q[7];
	assign stat.sp_zero   = (sp_q == '0);
	assign stat.sp_full   = (sp_q == lrp_pkg::SP_W'(lrp_pkg::STACK_DEPTH - 1));
	assign stat.red_limit = (red_q == lrp_pkg::RED_W'(lrp_pkg::REDUCE_LIMIT));
	assign stat.j_zero    = (j_q == '0);
	assign stat.rhs_zero  = (rhs_rdata_q == '0);
	assign stat.sym_match = (sym_rdata_q == rhs_rdata_q);
	assign stat.goto_zero = (act_rdata_q[7:0] == '0);
	assign stat.done      = done_q;
	assign stat.is_end    = is_end_q;
	assign stat.out_busy  = out_valid_q & ~out_ch.ready;

	assign out_ch.valid             = out_valid_q;
	assign out_ch.status            = out_status_q;
	assign out_ch.element_position  = out_pos_q;
	assign out_ch.offending_symbol  = out_sym_q;
	assign out_ch.failed_production = out_prod_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid_q && !out_ch.ready))
		else $error("result register overwritten");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_shift || cmd.push_goto) |-> !stat.sp_full)
		else $error("push on full stack");
	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !stat.sp_zero)
		else $error("pop on empty stack");
	a_red_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.prod_rd |-> !stat.red_limit)
		else $error("reduction count past limit");

endmodule
`default_nettype wire

>>> design/lrp_ctrl.sv
// ----------------------------------------------------------------------------
// lrp_ctrl - parser sequencer
// Takes input transactions and walks the shift/reduce/goto sequence.
// ----------------------------------------------------------------------------
`default_nettype none
module lrp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [2:0]         in_opcode,
	output logic                    in_ready,
	input  wire lrp_pkg::lrp_stat_t stat,
	output lrp_pkg::lrp_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_ACT, S_PROD, S_RHS_RD, S_RHS_CHK, S_GOTO_ST, S_GOTO_CHK
	} state_t;

	state_t state_q, state_d;
	logic   acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid & in_ready;

	always_comb begin
		cmd         = '0;
		cmd.act_rd  = lrp_pkg::ARD_NONE;
		cmd.emit_status = lrp_pkg::ST_SHIFTED;
		state_d     = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (in_opcode)
						lrp_pkg::OP_WR_ACTION: cmd.wr_action = 1'b1;
						lrp_pkg::OP_WR_HEADER: cmd.wr_header = 1'b1;
						lrp_pkg::OP_WR_RHS:    cmd.wr_rhs    = 1'b1;
						lrp_pkg::OP_START:     cmd.init      = 1'b1;
						lrp_pkg::OP_TOKEN, lrp_pkg::OP_END: begin
							if (!stat.done) begin
								cmd.load_item = 1'b1;
								cmd.act_rd    = lrp_pkg::ARD_LOOK;
								state_d       = S_ACT;
							end
						end
						default: ;
					endcase
				end
			end
			S_ACT: begin
				if (!stat.out_busy) begin
					state_d  = S_IDLE;
					cmd.emit = 1'b1;
					case (stat.kind)
						lrp_pkg::KIND_ERROR:  cmd.emit_status = lrp_pkg::ST_UNEXPECTED;
						lrp_pkg::KIND_ACCEPT: cmd.emit_status = lrp_pkg::ST_ACCEPTED;
						lrp_pkg::KIND_SHIFT: begin
							if (stat.sp_full) begin
								cmd.emit_status = lrp_pkg::ST_OVERFLOW;
							end else begin
								cmd.push_shift  = 1'b1;
								cmd.emit_status = stat.is_end ? lrp_pkg::ST_INCOMPLETE :
									lrp_pkg::ST_SHIFTED;
							end
						end
						default: begin
							if (stat.red_limit || stat.num_big) begin
								cmd.emit_status = lrp_pkg::ST_BADTABLE;
							end else begin
								cmd.emit    = 1'b0;
								cmd.prod_rd = 1'b1;
								state_d     = S_PROD;
							end
						end
					endcase
				end
			end
			S_PROD: begin
				cmd.load_j = 1'b1;
				state_d    = S_RHS_RD;
			end
			S_RHS_RD: begin
				if (stat.j_zero) begin
					cmd.st_rd = 1'b1;
					state_d   = S_GOTO_ST;
				end else begin
					cmd.rhs_rd = 1'b1;
					state_d    = S_RHS_CHK;
				end
			end
			S_RHS_CHK: begin
				if (stat.rhs_zero) begin
					cmd.j_dec = 1'b1;
					state_d   = S_RHS_RD;
				end else if (stat.sp_zero || !stat.sym_match) begin
					if (!stat.out_busy) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = lrp_pkg::ST_MISMATCH;
						state_d         = S_IDLE;
					end
				end else begin
					cmd.j_dec = 1'b1;
					cmd.pop   = 1'b1;
					state_d   = S_RHS_RD;
				end
			end
			S_GOTO_ST: begin
				cmd.tos_load = 1'b1;
				cmd.act_rd   = lrp_pkg::ARD_GOTO;
				state_d      = S_GOTO_CHK;
			end
			S_GOTO_CHK: begin
				if (stat.goto_zero || stat.sp_full) begin
					if (!stat.out_busy) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = stat.goto_zero ? lrp_pkg::ST_BADTABLE :
							lrp_pkg::ST_OVERFLOW;
						state_d         = S_IDLE;
					end
				end else begin
					cmd.push_goto = 1'b1;
					cmd.act_rd    = lrp_pkg::ARD_AFTER;
					state_d       = S_ACT;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_emit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == S_IDLE)
		else $error("result emitted without returning to idle");
	a_done_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && stat.done) |-> !cmd.load_item)
		else $error("item started after finished parse");
	a_goto_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tos_load |=> state_q == S_GOTO_CHK)
		else $error("goto lookup out of sequence");

endmodule
`default_nettype wire

>>> design/lr_table_parser_driver_unit.sv
// ----------------------------------------------------------------------------
// lr_table_parser_driver_unit - table-driven LR shift-reduce parser
// Loads action/goto and production tables, then parses a token stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one command transaction: action write, production header
//          write, right-side symbol write, start, token, or end of input.
//   out_ch carries one result transaction per token or end transaction while
//          a parse is open: status, token position, lookahead, and the failing
//          production for a mismatch. Table writes and start give no result.
// Flow:
//   Table writes and start are done as they are accepted. A token reads the
//   action table; a reduction reads the production header, checks each
//   right-side position against the stack and reads the goto entry, one step
//   at a time through registered memory reads. One transaction is in work at
//   a time; in_ch.ready is high only while the sequencer is idle.
// Reset:
//   arst_n clears the stack to state 1, the token count and the finished flag.
//   Table contents are undefined until written; start keeps them.
// Stall:
//   A result waits in the output register; if out_ch stalls and a second
//   result is ready, the sequencer holds until the register drains.
// ----------------------------------------------------------------------------
`default_nettype none
module lr_table_parser_driver_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lrp_in_if.sink     in_ch,
	lrp_out_if.source  out_ch
);

	lrp_pkg::lrp_cmd_t  cmd;
	lrp_pkg::lrp_stat_t stat;

	// sequencer: decodes transactions, steps shift/reduce/goto
	lrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_opcode (in_ch.opcode),
		.in_ready  (in_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// tables, stacks and result register
	lrp_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule
`default_nettype wire

>>> dv/lr_table_parser_driver_unit_tb.sv
// ----------------------------------------------------------------------------
// lr_table_parser_driver_unit_tb - self-checking bench of the LR parser driver
// Loads action/goto tables and productions, then feeds token streams. Every
// result is checked against a behavioral parser kept in step with each
// accepted command transaction.
// ----------------------------------------------------------------------------
`default_nettype none
module lr_table_parser_driver_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// opcodes with no meaning; the block must drop them
	localparam bit [2:0] OP_SPARE_LO = 3'd6;
	localparam bit [2:0] OP_SPARE_HI = 3'd7;

	typedef struct {
		bit [2:0] opcode;
		bit [7:0] table_state;
		bit [5:0] table_symbol;
		bit [1:0] action_kind;
		bit [7:0] action_number;
		bit [6:0] production_index;
		bit [2:0] rhs_position;
		bit [5:0] rhs_value;
		bit [3:0] rhs_length;
		bit [5:0] lhs_symbol;
		bit [5:0] token_symbol;
	} command_t;

	typedef struct {
		lrp_pkg::lrp_status_t status;
		bit [15:0]            position;
		bit [5:0]             symbol;
		bit [6:0]             production;
	} verdict_t;

	logic clk;
	logic arst_n;

	lrp_in_if  in_ch ();
	lrp_out_if out_ch ();

	lr_table_parser_driver_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Mirror of the tables; the known flags keep the stimulus away from
	// entries that were never written.
	bit [9:0] action_mem [16384];
	bit       action_known [16384];
	bit [3:0] length_mem [128];
	bit [5:0] lhs_mem [128];
	bit       header_known [128];
	bit [5:0] rhs_mem [1024];
	bit       rhs_known [1024];

	// Mirror of the parse stacks.
	bit [7:0] state_stk [64];
	bit [5:0] sym_stk [64];
	int       sp;
	int       tok_count;
	bit       finished;

	verdict_t pending_verdicts [$];
	int       errors;
	int       verdicts_seen;
	int       commands_sent;
	int       status_hits [8];
	bit       calm;
	int       stall_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#500_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void clear_stacks();
		foreach (state_stk[i]) begin
			state_stk[i] = '0;
			sym_stk[i]   = '0;
		end
		state_stk[0] = 8'd1;
		sp           = 0;
		tok_count    = 0;
		finished     = 1'b0;
	endfunction

	// Run the shift-reduce loop for one lookahead. Return 0 when the walk
	// would touch an unwritten entry or exceed the reduction budget.
	function automatic bit walk_parse(input bit [5:0] look, input bit is_end, input int lim,
			output lrp_pkg::lrp_status_t status, output bit [6:0] failed);
		int        reductions;
		bit [13:0] addr;
		bit [9:0]  entry;
		bit [7:0]  num;
		bit [6:0]  prod;
		int        len;
		bit [5:0]  rsym;
		bit [5:0]  lhs;
		bit [7:0]  target;
		reductions = 0;
		failed     = '0;
		status     = lrp_pkg::ST_UNEXPECTED;
		forever begin
			addr = {state_stk[sp], look};
			if (!action_known[addr])
				return 0;
			entry = action_mem[addr];
			num   = entry[7:0];
			case (lrp_pkg::lrp_kind_t'(entry[9:8]))
				lrp_pkg::KIND_ERROR: begin
					status = lrp_pkg::ST_UNEXPECTED;
					return 1;
				end
				lrp_pkg::KIND_ACCEPT: begin
					status = lrp_pkg::ST_ACCEPTED;
					return 1;
				end
				lrp_pkg::KIND_SHIFT: begin
					if (sp + 1 >= lrp_pkg::STACK_DEPTH) begin
						status = lrp_pkg::ST_OVERFLOW;
						return 1;
					end
					sp++;
					state_stk[sp] = num;
					sym_stk[sp]   = look;
					if (is_end) begin
						status = lrp_pkg::ST_INCOMPLETE;
						return 1;
					end
					if (tok_count < 65535)
						tok_count++;
					status = lrp_pkg::ST_SHIFTED;
					return 1;
				end
				default: begin
					if (reductions >= lrp_pkg::REDUCE_LIMIT || num >= 128) begin
						status = lrp_pkg::ST_BADTABLE;
						return 1;
					end
					if (reductions >= lim)
						return 0;
					reductions++;
					prod = num[6:0];
					if (!header_known[prod])
						return 0;
					len = length_mem[prod];
					for (int j = len; j > 0; j--) begin
						if (!rhs_known[{prod, 3'(j - 1)}])
							return 0;
						rsym = rhs_mem[{prod, 3'(j - 1)}];
						if (rsym != 0) begin
							if (sp == 0 || sym_stk[sp] != rsym) begin
								failed = prod;
								status = lrp_pkg::ST_MISMATCH;
								return 1;
							end
							sp--;
						end
					end
					lhs  = lhs_mem[prod];
					addr = {state_stk[sp], lhs};
					if (!action_known[addr])
						return 0;
					target = action_mem[addr][7:0];
					if (target == 0) begin
						status = lrp_pkg::ST_BADTABLE;
						return 1;
					end
					if (sp + 1 >= lrp_pkg::STACK_DEPTH) begin
						status = lrp_pkg::ST_OVERFLOW;
						return 1;
					end
					sp++;
					state_stk[sp] = target;
					sym_stk[sp]   = lhs;
				end
			endcase
		end
	endfunction

	// Commit the prediction for a token or end transaction, or roll back and
	// refuse it when it is not safe to send.
	function automatic bit offer_lookahead(input bit [5:0] look, input bit is_end,
			input int lim);
		bit [7:0]             st_save [64];
		bit [5:0]             sy_save [64];
		int                   sp_save;
		int                   cnt_save;
		lrp_pkg::lrp_status_t status;
		bit [6:0]             failed;
		verdict_t             v;
		if (finished)
			return 1;
		st_save    = state_stk;
		sy_save    = sym_stk;
		sp_save    = sp;
		cnt_save   = tok_count;
		v.position = (tok_count < 65535) ? 16'(tok_count + 1) : 16'hFFFF;
		v.symbol   = look;
		if (!walk_parse(look, is_end, lim, status, failed)) begin
			state_stk = st_save;
			sym_stk   = sy_save;
			sp        = sp_save;
			tok_count = cnt_save;
			return 0;
		end
		v.status     = status;
		v.production = (status == lrp_pkg::ST_MISMATCH) ? failed : 7'd0;
		if (status != lrp_pkg::ST_SHIFTED)
			finished = 1'b1;
		pending_verdicts = {pending_verdicts, v};
		return 1;
	endfunction

	// Apply a table write or start to the mirror; other opcodes are no-ops here.
	function automatic void note_command(input command_t c);
		case (c.opcode)
			lrp_pkg::OP_WR_ACTION: begin
				action_mem[{c.table_state, c.table_symbol}]   = {c.action_kind, c.action_number};
				action_known[{c.table_state, c.table_symbol}] = 1'b1;
			end
			lrp_pkg::OP_WR_HEADER: begin
				length_mem[c.production_index]   = (c.rhs_length > lrp_pkg::MAX_RHS) ?
					4'(lrp_pkg::MAX_RHS) : c.rhs_length;
				lhs_mem[c.production_index]      = c.lhs_symbol;
				header_known[c.production_index] = 1'b1;
			end
			lrp_pkg::OP_WR_RHS: begin
				rhs_mem[{c.production_index, c.rhs_position}]   = c.rhs_value;
				rhs_known[{c.production_index, c.rhs_position}] = 1'b1;
			end
			lrp_pkg::OP_START: clear_stacks();
			default: ;
		endcase
	endfunction

	// Fill every field at random so unused fields toggle too.
	function automatic command_t any_command(input bit [2:0] op);
		command_t c;
		c.opcode           = op;
		c.table_state      = 8'($urandom);
		c.table_symbol     = 6'($urandom);
		c.action_kind      = 2'($urandom);
		c.action_number    = 8'($urandom);
		c.production_index = 7'($urandom);
		c.rhs_position     = 3'($urandom);
		c.rhs_value        = 6'($urandom);
		c.rhs_length       = 4'($urandom);
		c.lhs_symbol       = 6'($urandom);
		c.token_symbol     = 6'($urandom);
		return c;
	endfunction

	// Drive one transaction after a random gap and hold it until accepted.
	task automatic send_command(input command_t c);
		int gap;
		int r;
		gap = 0;
		if (!calm) begin
			r   = $urandom_range(0, 99);
			gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		end
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid            <= 1'b1;
		in_ch.opcode           <= c.opcode;
		in_ch.table_state      <= c.table_state;
		in_ch.table_symbol     <= c.table_symbol;
		in_ch.action_kind      <= c.action_kind;
		in_ch.action_number    <= c.action_number;
		in_ch.production_index <= c.production_index;
		in_ch.rhs_position     <= c.rhs_position;
		in_ch.rhs_value        <= c.rhs_value;
		in_ch.rhs_length       <= c.rhs_length;
		in_ch.lhs_symbol       <= c.lhs_symbol;
		in_ch.token_symbol     <= c.token_symbol;
		do
			@(posedge clk);
		while (!in_ch.ready);
		commands_sent++;
	endtask

	task automatic issue(input command_t c);
		note_command(c);
		send_command(c);
	endtask

	task automatic write_action(input int st, input int sym, input lrp_pkg::lrp_kind_t kind,
			input int num);
		command_t c;
		c               = any_command(lrp_pkg::OP_WR_ACTION);
		c.table_state   = 8'(st);
		c.table_symbol  = 6'(sym);
		c.action_kind   = kind;
		c.action_number = 8'(num);
		issue(c);
	endtask

	task automatic write_header(input int prod, input int len, input int lhs);
		command_t c;
		c                  = any_command(lrp_pkg::OP_WR_HEADER);
		c.production_index = 7'(prod);
		c.rhs_length       = 4'(len);
		c.lhs_symbol       = 6'(lhs);
		issue(c);
	endtask

	task automatic write_rhs(input int prod, input int pos, input int sym);
		command_t c;
		c                  = any_command(lrp_pkg::OP_WR_RHS);
		c.production_index = 7'(prod);
		c.rhs_position     = 3'(pos);
		c.rhs_value        = 6'(sym);
		issue(c);
	endtask

	task automatic start_parse();
		issue(any_command(lrp_pkg::OP_START));
	endtask

	// Send a token (or end of input) once its prediction is committed.
	task automatic feed(input int sym, input bit is_end, input int lim, output bit sent);
		command_t c;
		c = any_command(is_end ? lrp_pkg::OP_END : lrp_pkg::OP_TOKEN);
		if (!is_end)
			c.token_symbol = 6'(sym);
		sent = offer_lookahead(is_end ? 6'd0 : 6'(sym), is_end, lim);
		if (sent)
			send_command(c);
	endtask

	task automatic feed_token(input int sym);
		bit sent;
		feed(sym, 1'b0, 1000, sent);
	endtask

	task automatic feed_end();
		bit sent;
		feed(0, 1'b1, 1000, sent);
	endtask

	// Small hand-built grammar: S -> a b (prod 0), plus rows that hit each
	// error path from state 1.
	task automatic test_directed_tables();
		write_action(1, 1, lrp_pkg::KIND_SHIFT, 2);
		write_action(2, 2, lrp_pkg::KIND_SHIFT, 3);
		write_action(2, 1, lrp_pkg::KIND_ERROR, 0);
		write_action(3, 0, lrp_pkg::KIND_REDUCE, 0);
		write_action(1, 10, lrp_pkg::KIND_ERROR, 4);   // goto on S
		write_action(4, 0, lrp_pkg::KIND_ACCEPT, 0);
		write_action(4, 8, lrp_pkg::KIND_ERROR, 0);
		write_action(1, 0, lrp_pkg::KIND_SHIFT, 5);
		write_action(5, 0, lrp_pkg::KIND_ERROR, 0);
		write_action(1, 3, lrp_pkg::KIND_SHIFT, 6);
		write_action(6, 3, lrp_pkg::KIND_SHIFT, 6);
		write_action(1, 4, lrp_pkg::KIND_REDUCE, 200);
		write_action(1, 5, lrp_pkg::KIND_REDUCE, 2);
		write_action(1, 11, lrp_pkg::KIND_ERROR, 0);   // goto of zero
		write_action(1, 6, lrp_pkg::KIND_REDUCE, 1);
		write_action(1, 7, lrp_pkg::KIND_REDUCE, 3);
		write_action(1, 12, lrp_pkg::KIND_ERROR, 7);
		write_action(7, 7, lrp_pkg::KIND_REDUCE, 4);
		write_action(1, 8, lrp_pkg::KIND_REDUCE, 5);
		write_action(1, 63, lrp_pkg::KIND_ACCEPT, 255);
		write_action(255, 32, lrp_pkg::KIND_ERROR, 0);
		write_header(0, 2, 10);
		write_rhs(0, 0, 1);
		write_rhs(0, 1, 2);
		write_header(1, 1, 10);
		write_rhs(1, 0, 7);
		write_header(2, 0, 11);
		write_header(3, 0, 12);
		write_header(4, 1, 12);
		write_rhs(4, 0, 12);
		write_header(5, 15, 10);              // length saturates to eight
		for (int p = 0; p < lrp_pkg::MAX_RHS; p++)
			write_rhs(5, p, 0);
		write_header(127, 8, 63);
		write_rhs(127, 7, 63);
	endtask

	task automatic test_directed_parses();
		command_t c;
		start_parse(); feed_token(1); feed_token(2); feed_end();   // accept after reduce
		feed_token(1);                                               // finished: no result
		start_parse(); feed_token(1); feed_token(1);                 // unexpected
		start_parse(); feed_end();                                   // shift on end
		start_parse(); feed_token(0); feed_end();                    // token symbol zero
		start_parse(); feed_token(4);                                // bad production
		start_parse(); feed_token(5);                                // zero goto
		start_parse(); feed_token(6);                                // pop from empty stack
		start_parse(); feed_token(8);                                // saturated length
		start_parse(); feed_token(63);                               // high symbol
		c = any_command(OP_SPARE_LO); send_command(c);               // unknown opcodes
		c = any_command(OP_SPARE_HI); send_command(c);
		feed_end();
	endtask

	task automatic test_stack_overflow();
		start_parse();
		for (int i = 0; i < lrp_pkg::STACK_DEPTH; i++)
			feed_token(3);
	endtask

	// An empty and a unit production that cycle between two states until the limit trips.
	task automatic test_reduce_runaway();
		bit sent;
		start_parse();
		feed(7, 1'b0, lrp_pkg::REDUCE_LIMIT + 1, sent);
	endtask

	// Random action for a table cell; nonterminal columns double as gotos.
	task automatic random_region_action(input int st, input int sym);
		int r;
		int kind_pick;
		r = $urandom_range(0, 99);
		if (sym >= 8)
			write_action(st, sym, lrp_pkg::lrp_kind_t'($urandom_range(0, 3)),
				(r < 8) ? 0 : $urandom_range(1, 15));
		else begin
			kind_pick = (r < 10) ? lrp_pkg::KIND_ERROR : (r < 50) ? lrp_pkg::KIND_SHIFT :
				(r < 85) ? lrp_pkg::KIND_REDUCE : lrp_pkg::KIND_ACCEPT;
			if (sym == 0 && r < 40)
				kind_pick = lrp_pkg::KIND_ACCEPT;
			if (kind_pick == lrp_pkg::KIND_REDUCE)
				write_action(st, sym, lrp_pkg::KIND_REDUCE,
					(r < 52) ? $urandom_range(128, 255) : $urandom_range(0, 7));
			else
				write_action(st, sym, lrp_pkg::lrp_kind_t'(kind_pick), $urandom_range(0, 15));
		end
	endtask

	task automatic random_production(input int prod);
		int len;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 3);
		write_header(prod, len, $urandom_range(8, 15));
		for (int p = 0; p < lrp_pkg::MAX_RHS; p++)
			write_rhs(prod, p, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 15));
	endtask

	task automatic load_random_tables();
		for (int st = 0; st < 16; st++)
			for (int sym = 0; sym < 16; sym++)
				random_region_action(st, sym);
		for (int p = 0; p < 8; p++)
			random_production(p);
	endtask

	// Mostly well-formed token streams over the loaded tables, mixed with
	// restarts, table rewrites and unknown opcodes.
	task automatic test_random_traffic(input int count);
		int  r;
		bit  sent;
		bit  is_end;
		command_t c;
		load_random_tables();
		start_parse();
		for (int n = 0; n < count; n++) begin
			if (n % 150 == 0)
				calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 72) begin
				sent = 1'b0;
				for (int t = 0; t < 8 && !sent; t++) begin
					is_end = ($urandom_range(0, 5) == 0);
					feed($urandom_range(0, 15), is_end, 200, sent);
				end
				if (!sent)
					start_parse();
			end else if (r < 80)
				start_parse();
			else if (r < 87)
				random_region_action($urandom_range(0, 15), $urandom_range(0, 15));
			else if (r < 93)
				random_production($urandom_range(0, 7));
			else if (r < 97) begin
				// writes far outside the parsing region
				write_action($urandom_range(16, 255), $urandom_range(0, 63),
					lrp_pkg::lrp_kind_t'($urandom_range(0, 3)), $urandom);
				write_header($urandom_range(8, 127), $urandom_range(0, 15), $urandom_range(0, 63));
				write_rhs($urandom_range(8, 127), $urandom_range(0, 7), $urandom_range(0, 63));
			end else begin
				c = any_command(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)));
				send_command(c);
			end
		end
	endtask

	// Result side: random stalls, a few long, with stretches of none.
	always @(posedge clk) begin
		if (calm)
			out_ch.ready <= 1'b1;
		else if (stall_left > 0) begin
			stall_left   <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 15) begin
			stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
				: $urandom_range(0, 2);
			out_ch.ready <= 1'b0;
		end else
			out_ch.ready <= 1'b1;
	end

	// Compare each result transaction with the oldest prediction.
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				errors++;
				$display("%0t: result expected none, actual status %0d", $time,
					out_ch.status);
			end else begin
				v = pending_verdicts.pop_front();
				verdicts_seen++;
				status_hits[v.status]++;
				if (out_ch.status !== v.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time, v.status,
						out_ch.status);
				end
				if (out_ch.element_position !== v.position) begin
					errors++;
					$display("%0t: element_position expected %0d actual %0d", $time,
						v.position, out_ch.element_position);
				end
				if (out_ch.offending_symbol !== v.symbol) begin
					errors++;
					$display("%0t: offending_symbol expected %0d actual %0d", $time,
						v.symbol, out_ch.offending_symbol);
				end
				if (out_ch.failed_production !== v.production) begin
					errors++;
					$display("%0t: failed_production expected %0d actual %0d", $time,
						v.production, out_ch.failed_production);
				end
			end
		end
	end

	initial begin
		int waited;
		in_ch.valid            = 1'b0;
		in_ch.opcode           = '0;
		in_ch.table_state      = '0;
		in_ch.table_symbol     = '0;
		in_ch.action_kind      = '0;
		in_ch.action_number    = '0;
		in_ch.production_index = '0;
		in_ch.rhs_position     = '0;
		in_ch.rhs_value        = '0;
		in_ch.rhs_length       = '0;
		in_ch.lhs_symbol       = '0;
		in_ch.token_symbol     = '0;
		out_ch.ready           = 1'b0;
		arst_n                 = 1'b0;
		calm                   = 1'b0;
		stall_left             = 0;
		clear_stacks();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_tables();
		test_directed_parses();
		test_stack_overflow();
		test_reduce_runaway();
		test_random_traffic(350);
		test_random_traffic(350);
		in_ch.valid <= 1'b0;

		// Drain outstanding results, then allow for trailing activity.
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("Drove %0d command transactions and compared %0d parse results",
			commands_sent, verdicts_seen);
		$display("Outcomes: shift %0d acc %0d unexp %0d mism %0d bad %0d inc %0d ovf %0d",
			status_hits[lrp_pkg::ST_SHIFTED], status_hits[lrp_pkg::ST_ACCEPTED],
			status_hits[lrp_pkg::ST_UNEXPECTED], status_hits[lrp_pkg::ST_MISMATCH],
			status_hits[lrp_pkg::ST_BADTABLE], status_hits[lrp_pkg::ST_INCOMPLETE],
			status_hits[lrp_pkg::ST_OVERFLOW]);
		if (errors == 0 && pending_verdicts.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
design/lrp_pkg.sv
design/lrp_in_if.sv
design/lrp_out_if.sv
design/lrp_datapath.sv
design/lrp_ctrl.sv
design/lr_table_parser_driver_unit.sv
dv/lr_table_parser_driver_unit_tb.sv
